### src/kslpd_pkg.sv
// Shared types and constants for the key short/long press detector.
// No dependencies; used by kslpd_tracker and key_short_long_press_detector.
`default_nettype none

package kslpd_pkg;

  // Fixed timing of the detector, in milliseconds.
  localparam int unsigned DEBOUNCE_MS  = 50;
  localparam int unsigned REPEAT_MS    = 300;
  localparam int unsigned TENTH_MS     = 100;

  // Legal range and fallback of the long-press threshold, in tenths of a second.
  localparam int unsigned LONG_MIN     = 4;
  localparam int unsigned LONG_MAX     = 50;
  localparam int unsigned LONG_DEFAULT = 10;

  // Width of the threshold in milliseconds (at most 50 * 100 = 5000).
  localparam int unsigned LONG_MS_W    = 13;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UNLOCKED          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_INPUT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_ENABLED  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TENTHS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_NUMBER    = 3'd4;

  // Configuration as held by the top level. The long-press threshold is kept
  // already scaled to milliseconds.
  typedef struct packed {
    logic                 unlocked;
    logic                 invert_input;
    logic                 feedback_enabled;
    logic [LONG_MS_W-1:0] long_ms;
    logic [7:0]           channel_number;
  } cfg_t;

  // One result of a poll.
  typedef struct packed {
    logic       feedback_on;
    logic       feedback_valid;
    logic [7:0] event_channel;
    logic [7:0] event_count;
    logic       event_long;
    logic       event_valid;
  } result_t;

endpackage

`default_nettype wire

### src/kslpd_tracker.sv
// Press state tracker: press start time, last long time and press counter,
// plus the decision logic for one poll. Depends on kslpd_pkg.
`default_nettype none

module kslpd_tracker #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire kslpd_pkg::cfg_t    cfg,
  input  wire                     commit,
  input  wire                     pin_high,
  input  wire [31:0]              now_ms,
  output kslpd_pkg::result_t      res,
  output logic                    emit
);

  logic [TIME_WIDTH-1:0] press_start_time, press_start_time_next;
  logic [TIME_WIDTH-1:0] last_long_time, last_long_time_next;
  logic [7:0]            press_counter, press_counter_next;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] now_nz;
  logic [TIME_WIDTH-1:0] held;
  logic [TIME_WIDTH-1:0] since_long;
  logic                  released;
  logic                  started;
  logic                  long_sent;
  logic                  ev;
  logic                  ev_long;
  logic                  fb;
  logic                  fb_on;

  assign now_t      = TIME_WIDTH'(now_ms);
  assign now_nz     = (now_t == '0) ? TIME_WIDTH'(1) : now_t;
  assign held       = now_t - press_start_time;
  assign since_long = now_t - last_long_time;
  assign released   = pin_high ^ cfg.invert_input;
  assign started    = (press_start_time != '0);
  assign long_sent  = (last_long_time != '0);

  always_comb begin
    press_start_time_next = press_start_time;
    last_long_time_next   = last_long_time;
    press_counter_next    = press_counter;
    ev      = 1'b0;
    ev_long = 1'b0;
    fb      = 1'b0;
    fb_on   = 1'b0;
    priority if (released) begin
      if (started) begin
        // A short press counts only when held at least the debounce time and
        // no long event went out during this press.
        if (held >= TIME_WIDTH'(kslpd_pkg::DEBOUNCE_MS) && !long_sent) begin
          press_counter_next = press_counter + 8'd1;
          ev = 1'b1;
        end
        press_start_time_next = '0;
        fb = cfg.feedback_enabled;
      end
    end else if (started) begin
      if (long_sent) begin
        // Repeat of the long event keeps the same count.
        if (since_long >= TIME_WIDTH'(kslpd_pkg::REPEAT_MS)) begin
          last_long_time_next = now_nz;
          ev      = 1'b1;
          ev_long = 1'b1;
        end
      end else if (held >= TIME_WIDTH'(cfg.long_ms)) begin
        press_counter_next  = press_counter + 8'd1;
        last_long_time_next = now_nz;
        ev      = 1'b1;
        ev_long = 1'b1;
      end
    end else begin
      press_start_time_next = now_nz;
      last_long_time_next   = '0;
      fb    = cfg.feedback_enabled;
      fb_on = cfg.feedback_enabled;
    end
  end

  always_comb begin
    res                = '0;
    res.event_valid    = ev;
    res.event_long     = ev_long;
    res.event_count    = ev ? press_counter_next : 8'd0;
    res.event_channel  = ev ? cfg.channel_number : 8'd0;
    res.feedback_valid = fb;
    res.feedback_on    = fb_on;
    emit               = cfg.unlocked && (ev || fb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start_time <= '0;
      last_long_time   <= '0;
      press_counter    <= 8'd0;
    end else if (commit && cfg.unlocked) begin
      press_start_time <= press_start_time_next;
      last_long_time   <= last_long_time_next;
      press_counter    <= press_counter_next;
    end
  end

endmodule

`default_nettype wire

### src/key_short_long_press_detector.sv
// Top level of the key short/long press detector: stream ports, configuration
// registers, input and output registers. Depends on kslpd_pkg, kslpd_tracker.
`default_nettype none

// Each request on the slave side is one poll of a push button: the raw pin
// level and a millisecond timestamp. After optional inversion, a low level
// means the key is pressed. A press gives a feedback-on result (when feedback
// is enabled); a release gives feedback off, and a short event with the
// incremented press count if the key was held at least 50 ms and no long
// event went out. Holding the key for long_press_tenths * 100 ms gives a long
// event with the incremented count, repeated every 300 ms with the same
// count. A poll that leads to nothing produces no request on the master side,
// and while the block is locked polls are dropped and the state is held.
// Timing: one poll per clock cycle is accepted unless a result waits on a
// stalled master side; a result passes the input and then the output register.
// The rate is set by the press state registers, which are updated from one poll
// in the cycle it leaves the input register so the next poll sees the new state.
// A stalled master side holds a pending result; the block then keeps taking
// polls only as long as they produce nothing to send. Configuration writes
// are taken at any clock edge and are meant to be made while the block is idle.
module key_short_long_press_detector #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                                    clk,
  input  wire                                    rst,
  // Slave side: polls.
  input  wire                                    s_tvalid,
  output logic                                   s_tready,
  input  wire  [39:0]                            s_tdata,   // pin_high, now_ms[31:0], zero pad
  // Master side: results.
  output logic                                   m_tvalid,
  input  wire                                    m_tready,
  output logic [23:0]                            m_tdata,   // event_valid, event_long,
                                                            // event_count[7:0],
                                                            // event_channel[7:0],
                                                            // feedback_valid, feedback_on,
                                                            // zero pad
  // Configuration write port.
  input  wire                                    cfg_we,
  input  wire  [kslpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [kslpd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  kslpd_pkg::cfg_t    cfg;
  kslpd_pkg::result_t res;
  kslpd_pkg::result_t out_res;

  logic        in_valid;
  logic        in_pin;
  logic [31:0] in_now;
  logic        emit;
  logic        out_free;
  logic        advance;
  logic [5:0]  tenths;
  logic [5:0]  tenths_ok;

  // Configuration registers. The long-press threshold is checked and scaled
  // to milliseconds as it is written, which keeps the multiply off the poll path.
  assign tenths    = cfg_data[5:0];
  assign tenths_ok = (tenths < 6'(kslpd_pkg::LONG_MIN) || tenths > 6'(kslpd_pkg::LONG_MAX))
                     ? 6'(kslpd_pkg::LONG_DEFAULT) : tenths;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unlocked         <= 1'b1;
      cfg.invert_input     <= 1'b0;
      cfg.feedback_enabled <= 1'b0;
      cfg.long_ms          <= kslpd_pkg::LONG_MS_W'(kslpd_pkg::LONG_DEFAULT *
                                                    kslpd_pkg::TENTH_MS);
      cfg.channel_number   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kslpd_pkg::REG_UNLOCKED:          cfg.unlocked         <= cfg_data[0];
        kslpd_pkg::REG_INVERT_INPUT:      cfg.invert_input     <= cfg_data[0];
        kslpd_pkg::REG_FEEDBACK_ENABLED:  cfg.feedback_enabled <= cfg_data[0];
        kslpd_pkg::REG_LONG_PRESS_TENTHS: cfg.long_ms <=
          kslpd_pkg::LONG_MS_W'(tenths_ok) *
          kslpd_pkg::LONG_MS_W'(kslpd_pkg::TENTH_MS);
        kslpd_pkg::REG_CHANNEL_NUMBER:    cfg.channel_number   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A poll leaves the input register when it has nothing to send, or when
  // the output register is free to take its result.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pin <= s_tdata[0];
      in_now <= s_tdata[32:1];
    end
  end

  kslpd_tracker #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .commit   (advance),
    .pin_high (in_pin),
    .now_ms   (in_now),
    .res      (res),
    .emit     (emit)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res};

  // A reportable poll never overwrites a result still waiting on the master side.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && emit && m_tvalid && !m_tready) |-> !advance)
    else $error("result register overwritten while stalled");

  // Every result sent carries an event or a feedback command.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.event_valid || out_res.feedback_valid))
    else $error("empty result sent");

  // Event fields stay zero when no event is sent.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.event_valid) |->
      (!out_res.event_long && out_res.event_count == 8'd0 &&
       out_res.event_channel == 8'd0))
    else $error("event fields set without an event");

  // A locked block drops polls without producing a result.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg.unlocked && !m_tvalid) |=> !m_tvalid)
    else $error("result produced while locked");

endmodule

`default_nettype wire

### sim/tb_key_short_long_press_detector.sv
// Self-checking testbench for key_short_long_press_detector: a directed table, then
// random press sequences and noise, checked against an in-bench press predictor.
// Depends on kslpd_pkg and the detector RTL.
`default_nettype none

module tb_key_short_long_press_detector;

  // Register indexes past the last real register. Writes to them must be ignored.
  localparam logic [kslpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [kslpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // Random polls to send after the directed table. Idling stops near the end.
  localparam int unsigned RANDOM_POLLS = 1850;
  localparam int unsigned CALM_FROM    = 1550;

  // How each row of the directed table is handled. A config row writes one
  // register. A poll row is checked against the predictor, against "no result",
  // or against a result typed into the table.
  typedef enum logic [1:0] {ROW_CFG, ROW_MODEL, ROW_NONE, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [kslpd_pkg::CFG_INDEX_W-1:0] idx;
    logic [kslpd_pkg::CFG_DATA_W-1:0]  data;
    logic                              pin;
    logic [31:0]                       now;
    kslpd_pkg::result_t                res;
  } row_t;

  // Clock, reset and the block's inputs. Every input has a known value from time 0.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [39:0]                       s_tdata   = '0;  // pin_high, now_ms[31:0], zero pad
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [23:0]                       m_tdata;         // event_valid, event_long,
                                                      // event_count[7:0],
                                                      // event_channel[7:0],
                                                      // feedback_valid, feedback_on,
                                                      // zero pad
  logic                              cfg_we    = 1'b0;
  logic [kslpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kslpd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  always #1 clk = ~clk;

  key_short_long_press_detector uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The predictor's copy of the configuration, with its reset values.
  logic       cf_unlocked = 1'b1;
  logic       cf_invert   = 1'b0;
  logic       cf_feedback = 1'b0;
  logic [5:0] cf_tenths   = 6'(kslpd_pkg::LONG_DEFAULT);
  logic [7:0] cf_channel  = 8'd0;

  // The predictor's copy of the press state. A time of zero means "not set", so
  // a press or a long event at time zero is stored as one.
  logic [31:0] press_t0    = 32'd0;
  logic [31:0] long_t0     = 32'd0;
  logic [7:0]  press_count = 8'd0;

  // Results that are owed by the block, oldest first.
  kslpd_pkg::result_t key_results_due[$];

  int unsigned errors      = 0;
  int unsigned polls_taken = 0;

  // Idling knobs. pacing puts gaps between polls. stalls makes the receiver
  // drop tready in bursts.
  bit          pacing     = 1'b1;
  bit          stalls     = 1'b1;
  int unsigned stall_left = 0;

  row_t        plan[$];
  logic [31:0] t;
  logic        pressed_pin;
  bit          calm;

  function automatic logic [31:0] nonzero(input logic [31:0] v);
    return (v == 32'd0) ? 32'd1 : v;
  endfunction

  function automatic kslpd_pkg::result_t mk_res(input logic ev, input logic lng,
                                                input logic [7:0] cnt,
                                                input logic [7:0] ch, input logic fbv,
                                                input logic fbo);
    kslpd_pkg::result_t r;
    r.event_valid    = ev;
    r.event_long     = lng;
    r.event_count    = cnt;
    r.event_channel  = ch;
    r.feedback_valid = fbv;
    r.feedback_on    = fbo;
    return r;
  endfunction

  // Applies one register write to the predictor's configuration. A threshold
  // outside the legal range falls back to the default. Unknown indexes do nothing.
  function automatic void apply_register(input logic [kslpd_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [kslpd_pkg::CFG_DATA_W-1:0] val);
    logic [5:0] v;
    v = val[5:0];
    case (idx)
      kslpd_pkg::REG_UNLOCKED:          cf_unlocked = val[0];
      kslpd_pkg::REG_INVERT_INPUT:      cf_invert   = val[0];
      kslpd_pkg::REG_FEEDBACK_ENABLED:  cf_feedback = val[0];
      kslpd_pkg::REG_LONG_PRESS_TENTHS:
        cf_tenths = (v < kslpd_pkg::LONG_MIN || v > kslpd_pkg::LONG_MAX)
                    ? 6'(kslpd_pkg::LONG_DEFAULT) : v;
      kslpd_pkg::REG_CHANNEL_NUMBER:    cf_channel  = val;
      default: ;
    endcase
  endfunction

  // Judges one poll and updates the press state. fires says whether the poll
  // owes a result. Unused result fields stay zero. All time differences wrap
  // at 32 bits.
  function automatic void judge_poll(input logic pin, input logic [31:0] now,
                                     output bit fires, output kslpd_pkg::result_t r);
    logic        ev;
    logic        lng;
    logic        fbv;
    logic        fbo;
    logic [31:0] held;
    logic [31:0] since_long;
    ev    = 1'b0;
    lng   = 1'b0;
    fbv   = 1'b0;
    fbo   = 1'b0;
    fires = 1'b0;
    r     = '0;
    if (!cf_unlocked) return;
    held       = now - press_t0;
    since_long = now - long_t0;
    if (pin ^ cf_invert) begin
      // Released. Only a release of a held key does anything.
      if (press_t0 != 32'd0) begin
        if (held >= kslpd_pkg::DEBOUNCE_MS && long_t0 == 32'd0) begin
          press_count = press_count + 8'd1;
          ev          = 1'b1;
        end
        press_t0 = 32'd0;
        fbv      = cf_feedback;
      end
    end else if (press_t0 != 32'd0) begin
      // Still held. First the long event, then repeats with the same count.
      if (long_t0 != 32'd0) begin
        if (since_long >= kslpd_pkg::REPEAT_MS) begin
          long_t0 = nonzero(now);
          ev      = 1'b1;
          lng     = 1'b1;
        end
      end else if (held >= 32'(cf_tenths) * kslpd_pkg::TENTH_MS) begin
        press_count = press_count + 8'd1;
        long_t0     = nonzero(now);
        ev          = 1'b1;
        lng         = 1'b1;
      end
    end else begin
      // A new press.
      press_t0 = nonzero(now);
      long_t0  = 32'd0;
      fbv      = cf_feedback;
      fbo      = cf_feedback;
    end
    fires = ev | fbv;
    if (ev) r = mk_res(1'b1, lng, press_count, cf_channel, 1'b0, 1'b0);
    r.feedback_valid = fbv;
    r.feedback_on    = fbo;
  endfunction

  task automatic row_cfg(input logic [kslpd_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [kslpd_pkg::CFG_DATA_W-1:0] val);
    row_t w;
    w      = '{kind: ROW_CFG, idx: idx, data: val, pin: 1'b0, now: 32'd0, res: '0};
    plan.push_back(w);
  endtask

  task automatic row_poll(input row_kind_t kind, input logic pin, input logic [31:0] now,
                          input kslpd_pkg::result_t res);
    row_t w;
    w = '{kind: kind, idx: '0, data: '0, pin: pin, now: now, res: res};
    plan.push_back(w);
  endtask

  // Raises one poll request and holds it until it is taken. tvalid stays high
  // afterward, so back-to-back polls need no extra edge. A typed row pushes its
  // own expectation, and the predictor still runs to keep its state in step.
  task automatic drive_poll(input logic pin, input logic [31:0] now, input row_kind_t kind,
                            input kslpd_pkg::result_t typed);
    bit                 fires;
    kslpd_pkg::result_t r;
    if (pacing && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, now, pin};
    do @(posedge clk); while (!s_tready);
    if (cf_unlocked) polls_taken++;
    judge_poll(pin, now, fires, r);
    case (kind)
      ROW_TYPED: key_results_due.push_back(typed);
      ROW_NONE:  ;
      default:   if (fires) key_results_due.push_back(r);
    endcase
  endtask

  task automatic poll(input logic pin, input logic [31:0] now);
    drive_poll(pin, now, ROW_MODEL, '0);
  endtask

  // Stops sending and waits until every owed result has come out. A poll that
  // owes nothing may still be in the pipe, so the task also waits for it to
  // pass before a register write.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (key_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write. cfg_we stays high so a run of writes takes one edge each. The
  // caller lowers it afterward.
  task automatic write_reg(input logic [kslpd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [kslpd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_register(idx, val);
  endtask

  // A random threshold. It is mostly short, so long events and repeats are
  // common, and sometimes it takes an edge value or a value out of range.
  // The top two data bits are junk that the block must mask off.
  function automatic logic [7:0] pick_tenths();
    logic [5:0] v;
    case ($urandom_range(0, 5))
      0:       v = 6'(kslpd_pkg::LONG_MIN);
      1:       v = 6'(kslpd_pkg::LONG_MAX);
      2, 3:    v = 6'($urandom_range(kslpd_pkg::LONG_MIN, 12));
      4:       v = 6'($urandom_range(0, 63));
      default: v = ($urandom_range(0, 1) != 0)
                   ? 6'($urandom_range(0, kslpd_pkg::LONG_MIN - 1))
                   : 6'($urandom_range(kslpd_pkg::LONG_MAX + 1, 63));
    endcase
    return {2'($urandom_range(0, 3)), v};
  endfunction

  // Time between polls while the key is held. The ranges reach the debounce
  // edge, ordinary spacing, the repeat edge, and long jumps.
  function automatic logic [31:0] pick_hold_gap();
    case ($urandom_range(0, 7))
      0:       return 32'($urandom_range(0, 60));
      6:       return 32'($urandom_range(kslpd_pkg::REPEAT_MS - 10,
                                         kslpd_pkg::REPEAT_MS + 10));
      7:       return 32'($urandom_range(400, 2000));
      default: return 32'($urandom_range(20, 400));
    endcase
  endfunction

  // The receiver. tready drops in bursts while stalls is set.
  always @(posedge clk) begin
    if (stalls && stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker. Every result the block hands over is matched against the
  // oldest owed one, field by field.
  kslpd_pkg::result_t got;
  kslpd_pkg::result_t want;

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = kslpd_pkg::result_t'(m_tdata[19:0]);
      if (key_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = key_results_due.pop_front();
        check_field("event_valid",    8'(want.event_valid),    8'(got.event_valid));
        check_field("event_long",     8'(want.event_long),     8'(got.event_long));
        check_field("event_count",    want.event_count,        got.event_count);
        check_field("event_channel",  want.event_channel,      got.event_channel);
        check_field("feedback_valid", 8'(want.feedback_valid), 8'(got.feedback_valid));
        check_field("feedback_on",    8'(want.feedback_on),    8'(got.feedback_on));
        check_field("tdata pad",      8'd0,                    8'(m_tdata[23:20]));
      end
    end
  end

  // Hard stop.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    // Directed table. Expected results are typed in where they follow at once
    // from the rules. The reset defaults are: unlocked, no inversion, no
    // feedback, a threshold of 1000 ms, and channel 0.
    row_cfg(kslpd_pkg::REG_FEEDBACK_ENABLED, 8'h01);
    row_cfg(kslpd_pkg::REG_CHANNEL_NUMBER,   8'hFF);
    // A press at time zero is stored as time one. It is held up to the threshold
    // and then one repeat follows.
    row_poll(ROW_TYPED, 1'b0, 32'd0,    mk_res(1'b0, 1'b0, 8'd0, 8'h00, 1'b1, 1'b1));
    row_poll(ROW_NONE,  1'b0, 32'd1000, '0);
    row_poll(ROW_TYPED, 1'b0, 32'd1001, mk_res(1'b1, 1'b1, 8'd1, 8'hFF, 1'b0, 1'b0));
    row_poll(ROW_NONE,  1'b0, 32'd1300, '0);
    row_poll(ROW_TYPED, 1'b0, 32'd1301, mk_res(1'b1, 1'b1, 8'd1, 8'hFF, 1'b0, 1'b0));
    // After a long event, a release sends no short event.
    row_poll(ROW_TYPED, 1'b1, 32'd1400, mk_res(1'b0, 1'b0, 8'd0, 8'h00, 1'b1, 1'b0));
    row_poll(ROW_NONE,  1'b1, 32'd1500, '0);
    // A short press of exactly the debounce time across the time wrap, then one
    // a millisecond too short.
    row_poll(ROW_TYPED, 1'b0, 32'hFFFF_FFF0, mk_res(1'b0, 1'b0, 8'd0, 8'h00, 1'b1, 1'b1));
    row_poll(ROW_TYPED, 1'b1, 32'h0000_0022, mk_res(1'b1, 1'b0, 8'd2, 8'hFF, 1'b1, 1'b0));
    row_poll(ROW_TYPED, 1'b0, 32'd100,       mk_res(1'b0, 1'b0, 8'd0, 8'h00, 1'b1, 1'b1));
    row_poll(ROW_TYPED, 1'b1, 32'd149,       mk_res(1'b0, 1'b0, 8'd0, 8'h00, 1'b1, 1'b0));
    // Feedback goes off. Only bit 0 of the data counts. A long event at time zero
    // is stored as time one, and the repeat is timed from there.
    row_cfg(kslpd_pkg::REG_FEEDBACK_ENABLED, 8'hFE);
    row_cfg(kslpd_pkg::REG_CHANNEL_NUMBER,   8'h5A);
    row_poll(ROW_NONE,  1'b0, 32'hFFFF_FC00, '0);
    row_poll(ROW_TYPED, 1'b0, 32'd0,         mk_res(1'b1, 1'b1, 8'd3, 8'h5A, 1'b0, 1'b0));
    row_poll(ROW_NONE,  1'b0, 32'd300,       '0);
    row_poll(ROW_TYPED, 1'b0, 32'd301,       mk_res(1'b1, 1'b1, 8'd3, 8'h5A, 1'b0, 1'b0));
    row_poll(ROW_NONE,  1'b1, 32'hFFFF_FFFF, '0);
    // Inverted input with the shortest threshold.
    row_cfg(kslpd_pkg::REG_INVERT_INPUT,      8'h01);
    row_cfg(kslpd_pkg::REG_LONG_PRESS_TENTHS, 8'(kslpd_pkg::LONG_MIN));
    row_poll(ROW_MODEL, 1'b1, 32'd1000, '0);
    row_poll(ROW_MODEL, 1'b1, 32'd1400, '0);
    row_poll(ROW_MODEL, 1'b0, 32'd1500, '0);
    // Locked: polls are dropped. Writes to unknown indexes are ignored.
    row_cfg(kslpd_pkg::REG_UNLOCKED, 8'h00);
    row_poll(ROW_NONE,  1'b1, 32'd2000, '0);
    row_cfg(REG_SPARE_FIRST, 8'hFF);
    row_cfg(REG_SPARE_LAST,  8'h00);
    row_cfg(kslpd_pkg::REG_UNLOCKED,     8'h01);
    row_cfg(kslpd_pkg::REG_INVERT_INPUT, 8'h00);
    // The longest threshold, then out-of-range values and masked upper bits.
    row_cfg(kslpd_pkg::REG_LONG_PRESS_TENTHS, 8'(kslpd_pkg::LONG_MAX));
    row_poll(ROW_MODEL, 1'b0, 32'd10000, '0);
    row_poll(ROW_MODEL, 1'b0, 32'd14999, '0);
    row_poll(ROW_MODEL, 1'b0, 32'd15000, '0);
    row_poll(ROW_MODEL, 1'b1, 32'd16000, '0);
    row_cfg(kslpd_pkg::REG_LONG_PRESS_TENTHS, 8'd3);
    row_cfg(kslpd_pkg::REG_LONG_PRESS_TENTHS, 8'hC4);
    row_poll(ROW_MODEL, 1'b0, 32'd20000, '0);
    row_poll(ROW_MODEL, 1'b0, 32'd20400, '0);
    row_poll(ROW_MODEL, 1'b1, 32'd20500, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        cfg_we <= 1'b0;
        drive_poll(plan[i].pin, plan[i].now, plan[i].kind, plan[i].res);
      end
    end

    // Random phases. Each phase starts only after every owed result has come
    // out, so the sender pauses once per phase. The phase then rewrites some
    // registers and sends a few press sequences. A sequence is released polls,
    // a press, polls while held, and a release. Some sequences are plain noise
    // with random levels and random times.
    polls_taken = 0;
    while (polls_taken < RANDOM_POLLS) begin
      wait_idle();
      calm   = polls_taken >= CALM_FROM;
      pacing = !calm && $urandom_range(0, 3) != 0;
      stalls = !calm && $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1) != 0)
        write_reg(kslpd_pkg::REG_UNLOCKED,
                  {7'($urandom), 1'($urandom_range(0, 9) != 0)});
      if ($urandom_range(0, 1) != 0)
        write_reg(kslpd_pkg::REG_INVERT_INPUT, 8'($urandom));
      if ($urandom_range(0, 1) != 0)
        write_reg(kslpd_pkg::REG_FEEDBACK_ENABLED, 8'($urandom));
      if ($urandom_range(0, 1) != 0)
        write_reg(kslpd_pkg::REG_LONG_PRESS_TENTHS, pick_tenths());
      if ($urandom_range(0, 1) != 0)
        write_reg(kslpd_pkg::REG_CHANNEL_NUMBER, 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 8'($urandom));
      cfg_we <= 1'b0;

      // Some phases start just below the wrap of the millisecond counter.
      t = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3000))
                                      : 32'($urandom);
      pressed_pin = cf_invert;
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) poll(1'($urandom_range(0, 1)), 32'($urandom));
        end else begin
          repeat ($urandom_range(0, 2)) begin
            t = t + 32'($urandom_range(0, 500));
            poll(!pressed_pin, t);
          end
          t = t + 32'($urandom_range(1, 500));
          poll(pressed_pin, t);
          repeat ($urandom_range(0, 14)) begin
            t = t + pick_hold_gap();
            poll(pressed_pin, t);
          end
          // The release sometimes lands near the debounce edge.
          t = t + (($urandom_range(0, 1) != 0) ? 32'($urandom_range(40, 60))
                                               : 32'($urandom_range(0, 300)));
          poll(!pressed_pin, t);
        end
      end
    end

    // Drain, then keep the clock running to catch any stray result.
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
